// ----- sv/bfha_pkg.sv -----
`timescale 1ns / 1ps
package bfha_pkg;

  localparam int OFF_W = 20;
  localparam int LEN_W = 21;
  localparam int REQ_W = 21;
  localparam int ST_W  = 3;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_OFFSET_BITS  = 20;
  localparam logic [LEN_W-1:0] HEAP_RESET = 21'd1048576;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_BADPTR = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    WR_INIT  = 2'd0,
    WR_SPARE = 2'd1,
    WR_BEST  = 2'd2,
    WR_MERGE = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    SCAN_FIT   = 2'd0,
    SCAN_FIND  = 2'd1,
    SCAN_NEIGH = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic       load;
    logic       clr_scan;
    logic       scan_en;
    scan_mode_t mode;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       out_load;
    status_t    code;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic size_zero;
    logic scan_done;
    logic best_found;
    logic spare_found;
    logic rest_nz;
    logic cur_found;
    logic cur_busy;
  } stat_t;

endpackage

// ----- sv/bfha_ram.sv -----
`timescale 1ns / 1ps
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bfha_ctrl.sv -----
`timescale 1ns / 1ps
module bfha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cfg_valid,
  output logic            busy,
  output logic            cfg_ready,
  input  bfha_pkg::stat_t stat,
  output bfha_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_A_SCAN, S_A_DECIDE, S_A_WSPARE, S_A_WBEST,
    S_F_SCAN1, S_F_CHECK, S_F_SCAN2, S_F_WRITE
  } state_t;

  state_t state, state_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.mode     = bfha_pkg::SCAN_FIT;
    cmd.wr_sel   = bfha_pkg::WR_INIT;
    cmd.code     = bfha_pkg::ST_OK;
    unique case (state)
      S_INIT: begin
        cmd.wr_en  = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end else if (cfg_valid) begin
          state_next = S_INIT;
        end
      end
      S_DISPATCH: begin
        cmd.clr_scan = 1'b1;
        if (stat.action) begin
          state_next = S_F_SCAN1;
        end else if (stat.size_zero) begin
          cmd.out_load = 1'b1;
          cmd.code     = bfha_pkg::ST_ZERO;
          state_next   = S_IDLE;
        end else begin
          state_next = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = bfha_pkg::SCAN_FIT;
        if (stat.scan_done) state_next = S_A_DECIDE;
      end
      S_A_DECIDE: begin
        if (!stat.best_found) begin
          cmd.out_load = 1'b1;
          cmd.code     = bfha_pkg::ST_NOFIT;
          state_next   = S_IDLE;
        end else if (stat.rest_nz && !stat.spare_found) begin
          cmd.out_load = 1'b1;
          cmd.code     = bfha_pkg::ST_FULL;
          state_next   = S_IDLE;
        end else if (stat.rest_nz) begin
          state_next = S_A_WSPARE;
        end else begin
          state_next = S_A_WBEST;
        end
      end
      S_A_WSPARE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = bfha_pkg::WR_SPARE;
        state_next = S_A_WBEST;
      end
      S_A_WBEST: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = bfha_pkg::WR_BEST;
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_F_SCAN1: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = bfha_pkg::SCAN_FIND;
        if (stat.scan_done) state_next = S_F_CHECK;
      end
      S_F_CHECK: begin
        if (!stat.cur_found || !stat.cur_busy) begin
          cmd.out_load = 1'b1;
          cmd.code     = bfha_pkg::ST_BADPTR;
          state_next   = S_IDLE;
        end else begin
          cmd.clr_scan = 1'b1;
          state_next   = S_F_SCAN2;
        end
      end
      S_F_SCAN2: begin
        cmd.scan_en = 1'b1;
        cmd.mode    = bfha_pkg::SCAN_NEIGH;
        if (stat.scan_done) state_next = S_F_WRITE;
      end
      S_F_WRITE: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = bfha_pkg::WR_MERGE;
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/bfha_dp.sv -----
`timescale 1ns / 1ps
module bfha_dp #(
  parameter int MAX_SEGMENTS = bfha_pkg::DEF_MAX_SEGMENTS,
  parameter int OFFSET_BITS  = bfha_pkg::DEF_OFFSET_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bfha_pkg::LEN_W-1:0]  cfg_data,
  input  logic                        action,
  input  logic [bfha_pkg::REQ_W-1:0]  request_bytes,
  input  logic [bfha_pkg::OFF_W-1:0]  release_offset,
  input  bfha_pkg::cmd_t              cmd,
  output bfha_pkg::stat_t             stat,
  output logic                        result_valid,
  output logic [bfha_pkg::OFF_W-1:0]  block_offset,
  output logic [bfha_pkg::LEN_W-1:0]  granted_bytes,
  output logic [bfha_pkg::ST_W-1:0]   status
);

  localparam int OW = bfha_pkg::OFF_W;
  localparam int LW = bfha_pkg::LEN_W;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam int EW = OW + LW;
  localparam logic [63:0] OFF_LIM = 64'd1 << OFFSET_BITS;
  localparam logic [LW-1:0] HEAP_LIM =
    (OFF_LIM < 64'd1048576) ? LW'(OFF_LIM) : LW'(1048576);

  logic [LW-1:0]   heap;
  logic [LW-1:0]   heap_clamp;
  logic            act;
  logic [LW:0]     size;
  logic [OW-1:0]   addr;

  logic [MAX_SEGMENTS-1:0] valid_q, busy_q;

  logic [CW-1:0]   cnt;
  logic            p_vld;
  logic [IW-1:0]   p_idx;

  logic            we;
  logic [IW-1:0]   waddr;
  logic [EW-1:0]   wdata, rdata;
  logic [OW-1:0]   r_st;
  logic [LW-1:0]   r_len;
  logic            r_v, r_b;

  logic            best_f, spare_f, cur_f, cur_b, nb_f, nb_b, pr_f;
  logic [IW-1:0]   best, spare, cur, nb, pr;
  logic [OW-1:0]   best_st, cur_st, pr_st;
  logic [LW-1:0]   best_len, cur_len, nb_len, pr_len;
  logic [LW-1:0]   cur_end, mlen, plen;
  logic [LW:0]     r_end;

  // Clamp the written heap size to the addressable range, whole words, at least one word
  always_comb begin
    heap_clamp = (cfg_data > HEAP_LIM) ? HEAP_LIM : cfg_data;
    heap_clamp = {heap_clamp[LW-1:2], 2'b00};
    if (heap_clamp < LW'(4)) heap_clamp = LW'(4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap <= bfha_pkg::HEAP_RESET;
    end else if (cfg_we) begin
      heap <= heap_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action;
      size <= ({1'b0, request_bytes} + (LW+1)'(3)) & ~(LW+1)'(3);
      addr <= release_offset;
    end
  end

  // Scan sequencer: one table read a cycle while scan_en is set, read data registered and back in the next cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_scan) begin
      cnt   <= '0;
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.scan_en && (cnt != CW'(MAX_SEGMENTS));
      if (cmd.scan_en && (cnt != CW'(MAX_SEGMENTS))) cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= cnt[IW-1:0];
  end

  bfha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (rdata)
  );

  assign r_st    = rdata[EW-1:LW];
  assign r_len   = rdata[LW-1:0];
  assign r_v     = valid_q[p_idx];
  assign r_b     = busy_q[p_idx];
  assign r_end   = {1'b0, LW'(r_st)} + {1'b0, r_len};
  assign cur_end = LW'(cur_st) + cur_len;
  assign mlen    = cur_len + ((nb_f && !nb_b) ? nb_len : '0);
  assign plen    = pr_len + mlen;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_f  <= 1'b0;
      spare_f <= 1'b0;
      cur_f   <= 1'b0;
      nb_f    <= 1'b0;
      pr_f    <= 1'b0;
    end else if (p_vld) begin
      unique case (cmd.mode)
        bfha_pkg::SCAN_FIT: begin
          if (r_v && !r_b && ({1'b0, r_len} >= size) &&
              (!best_f || r_len < best_len || (r_len == best_len && r_st < best_st))) begin
            best_f   <= 1'b1;
            best     <= p_idx;
            best_st  <= r_st;
            best_len <= r_len;
          end
          if (!r_v && !spare_f) begin
            spare_f <= 1'b1;
            spare   <= p_idx;
          end
        end
        bfha_pkg::SCAN_FIND: begin
          if (r_v && r_st == addr && !cur_f) begin
            cur_f   <= 1'b1;
            cur     <= p_idx;
            cur_st  <= r_st;
            cur_len <= r_len;
            cur_b   <= r_b;
          end
        end
        bfha_pkg::SCAN_NEIGH: begin
          if (r_v && LW'(r_st) == cur_end && !nb_f) begin
            nb_f   <= 1'b1;
            nb     <= p_idx;
            nb_len <= r_len;
            nb_b   <= r_b;
          end
          if (r_v && !r_b && p_idx != cur && r_end == {1'b0, LW'(cur_st)} && !pr_f) begin
            pr_f   <= 1'b1;
            pr     <= p_idx;
            pr_st  <= r_st;
            pr_len <= r_len;
          end
        end
        default: ;
      endcase
    end
  end

  // Table write port
  always_comb begin
    we    = cmd.wr_en;
    waddr = '0;
    wdata = '0;
    unique case (cmd.wr_sel)
      bfha_pkg::WR_INIT:  wdata = {OW'(0), heap};
      bfha_pkg::WR_SPARE: begin
        waddr = spare;
        wdata = {best_st + size[OW-1:0], best_len - size[LW-1:0]};
      end
      bfha_pkg::WR_BEST: begin
        waddr = best;
        wdata = {best_st, size[LW-1:0]};
      end
      bfha_pkg::WR_MERGE: begin
        waddr = pr_f ? pr : cur;
        wdata = pr_f ? {pr_st, plen} : {cur_st, mlen};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      busy_q  <= '0;
    end else if (cmd.wr_en) begin
      unique case (cmd.wr_sel)
        bfha_pkg::WR_INIT: begin
          valid_q    <= '0;
          valid_q[0] <= 1'b1;
          busy_q     <= '0;
        end
        bfha_pkg::WR_SPARE: begin
          valid_q[spare] <= 1'b1;
          busy_q[spare]  <= 1'b0;
        end
        bfha_pkg::WR_BEST: busy_q[best] <= 1'b1;
        bfha_pkg::WR_MERGE: begin
          busy_q[cur] <= 1'b0;
          if (nb_f && !nb_b) valid_q[nb] <= 1'b0;
          if (pr_f) valid_q[cur] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.code;
      if (cmd.code != bfha_pkg::ST_OK) begin
        block_offset  <= '0;
        granted_bytes <= '0;
      end else if (act) begin
        block_offset  <= pr_f ? pr_st : cur_st;
        granted_bytes <= pr_f ? plen : mlen;
      end else begin
        block_offset  <= best_st;
        granted_bytes <= size[LW-1:0];
      end
    end
  end

  assign stat.action      = act;
  assign stat.size_zero   = (size == '0);
  assign stat.scan_done   = (cnt == CW'(MAX_SEGMENTS)) && !p_vld;
  assign stat.best_found  = best_f;
  assign stat.spare_found = spare_f;
  assign stat.rest_nz     = (best_len != size[LW-1:0]);
  assign stat.cur_found   = cur_f;
  assign stat.cur_busy    = cur_b;

endmodule

// ----- sv/best_fit_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                               Transfer
// request   start, busy, action, request_bytes, release_offset  start & !busy
// result    result_valid, block_offset, granted_bytes, status   result_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_data (heap_bytes)         cfg_valid & cfg_ready
//
// The time from request transfer to result transfer is set by the sequential walk over
// the segment table through its single read port: allocate walks it once (and skips the
// spare write with no split), free walks it twice.
// Reset and every heap size write rebuild entry zero in the S_INIT state.
// The result strobe lasts one cycle; the receiver cannot stall it.
module best_fit_heap_allocator_core #(
  parameter int MAX_SEGMENTS = bfha_pkg::DEF_MAX_SEGMENTS,
  parameter int OFFSET_BITS  = bfha_pkg::DEF_OFFSET_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [bfha_pkg::REQ_W-1:0]  request_bytes,
  input  logic [bfha_pkg::OFF_W-1:0]  release_offset,
  output logic                        result_valid,
  output logic [bfha_pkg::OFF_W-1:0]  block_offset,
  output logic [bfha_pkg::LEN_W-1:0]  granted_bytes,
  output logic [bfha_pkg::ST_W-1:0]   status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfha_pkg::LEN_W-1:0]  cfg_data
);

  bfha_pkg::cmd_t  cmd;
  bfha_pkg::stat_t stat;

  // Controller: sequence scans, table writes and the result transfer
  bfha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: segment table, scan compare logic and result registers
  bfha_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .action         (action),
    .request_bytes  (request_bytes),
    .release_offset (release_offset),
    .cmd            (cmd),
    .stat           (stat),
    .result_valid   (result_valid),
    .block_offset   (block_offset),
    .granted_bytes  (granted_bytes),
    .status         (status)
  );

endmodule
